[rtl/core/packet_file_receiver_sum_check_macros.svh]
// assertion macros for the packet file receiver checker
// expects clk and rst_n in the scope where a macro is used
`ifndef PACKET_FILE_RECEIVER_SUM_CHECK_MACROS_SVH
`define PACKET_FILE_RECEIVER_SUM_CHECK_MACROS_SVH

// same-cycle implication, held off during reset
`define PFRSC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define PFRSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/pfrsc_pkg.sv]
// types and codes shared by the packet file receiver modules
// no dependencies
package pfrsc_pkg;

  localparam int LEN_W = 20;
  localparam int SUM_W = 32;
  localparam int BYTE_W = 8;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 2;

  // request codes
  localparam logic [1:0] REQ_START   = 2'd0;
  localparam logic [1:0] REQ_BYTE    = 2'd1;
  localparam logic [1:0] REQ_TIMEOUT = 2'd2;

  // result codes
  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_ACCEPT = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;
  localparam logic [1:0] KIND_ABORT  = 2'd3;

  // register byte addresses
  localparam logic [CFG_ADDR_W-1:0] ADDR_FILE_LENGTH = 2'd0;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_DATA  = 3'b010,
    PH_CHECK = 3'b100
  } phase_t;

  // item held in the input register
  typedef struct packed {
    logic              valid;
    logic [1:0]        req_type;
    logic [BYTE_W-1:0] rx_byte;
  } stage_t;

  // result produced by the core for the output register
  typedef struct packed {
    logic              valid;
    logic [1:0]        result_kind;
    logic [BYTE_W-1:0] data_out;
    logic              transfer_done;
  } result_t;

endpackage

[rtl/core/pfrsc_chan_if.sv]
// valid/ready channels for request beats and result beats
// depends on pfrsc_pkg
interface pfrsc_in_if;
  import pfrsc_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        req_type;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output req_type, output rx_byte, input ready);
  modport sink (input valid, input req_type, input rx_byte, output ready);
endinterface

interface pfrsc_out_if;
  import pfrsc_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        result_kind;
  logic [BYTE_W-1:0] data_out;
  logic              transfer_done;

  modport source (output valid, output result_kind, output data_out,
                  output transfer_done, input ready);
  modport sink (input valid, input result_kind, input data_out,
                input transfer_done, output ready);
endinterface

[rtl/core/packet_file_receiver_sum_check.sv]
// packet file receiver with additive checksum, top level
// depends on pfrsc_pkg, pfrsc_chan_if, pfrsc_cfg_regs, pfrsc_in_stage, pfrsc_core,
// pfrsc_out_stage
//
// usage:
//   write file_length at byte address 0 of the cfg port while the block is idle.
//   in_ch carries request beats: start, received byte, or receive timeout.
//   out_ch carries result beats: tentative data byte, packet accept,
//   packet reject, or abort. a request beat yields zero or one result beat.
//   each packet is min(remaining, PACKET_BYTES) data bytes then a 4-byte
//   little-endian checksum; a reject means the same packet is sent again.
// timing:
//   a request beat lands in the input register; when the result register is free,
//   the state updates and the result register loads, so out_ch.valid is registered.
//   one beat per cycle is sustained while out_ch takes every result beat; a stall
//   on out_ch holds the state update between those two registers.
// reset and stall:
//   rst_n (synchronous) clears the length register, the transfer state and both
//   pipeline registers; the block is then idle. when out_ch stalls, the result
//   register holds, the input register fills and in_ch.ready drops once both
//   are full; nothing is lost.
module packet_file_receiver_sum_check #(
  parameter int PACKET_BYTES = 1000
) (
  input  logic                             clk,
  input  logic                             rst_n,
  pfrsc_in_if.sink                         in_ch,
  pfrsc_out_if.source                      out_ch,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [pfrsc_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [pfrsc_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [pfrsc_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                             cfg_pready
);
  import pfrsc_pkg::*;

  logic [LEN_W-1:0] file_length;
  stage_t           stage;
  result_t          result;
  logic             advance;

  pfrsc_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (cfg_psel),
    .penable     (cfg_penable),
    .pwrite      (cfg_pwrite),
    .paddr       (cfg_paddr),
    .pwdata      (cfg_pwdata),
    .prdata      (cfg_prdata),
    .pready      (cfg_pready),
    .file_length (file_length)
  );

  pfrsc_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .req_type (in_ch.req_type),
    .rx_byte  (in_ch.rx_byte),
    .advance  (advance),
    .stage    (stage)
  );

  pfrsc_core #(
    .PACKET_BYTES (PACKET_BYTES)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .stage       (stage),
    .advance     (advance),
    .file_length (file_length),
    .result      (result)
  );

  pfrsc_out_stage u_out (
    .clk           (clk),
    .rst_n         (rst_n),
    .result        (result),
    .advance       (advance),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .result_kind   (out_ch.result_kind),
    .data_out      (out_ch.data_out),
    .transfer_done (out_ch.transfer_done)
  );
endmodule

[rtl/core/pfrsc_cfg_regs.sv]
// apb-style register port holding the file length
// depends on pfrsc_pkg
module pfrsc_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [pfrsc_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [pfrsc_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [pfrsc_pkg::CFG_DATA_W-1:0] prdata,
  output logic                             pready,
  output logic [pfrsc_pkg::LEN_W-1:0]      file_length
);
  import pfrsc_pkg::*;

  logic [LEN_W-1:0] file_length_r;
  logic [LEN_W-1:0] file_length_nxt;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr == ADDR_FILE_LENGTH);

  always_comb begin
    file_length_nxt = file_length_r;
    if (wr_en) begin
      file_length_nxt = pwdata[LEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      file_length_r <= '0;
    end else begin
      file_length_r <= file_length_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == ADDR_FILE_LENGTH) begin
      prdata = {{(CFG_DATA_W-LEN_W){1'b0}}, file_length_r};
    end
  end

  assign file_length = file_length_r;
endmodule

[rtl/core/pfrsc_in_stage.sv]
// input register for request beats
// depends on pfrsc_pkg
module pfrsc_in_stage (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   req_type,
  input  logic [pfrsc_pkg::BYTE_W-1:0] rx_byte,
  input  logic                         advance,
  output pfrsc_pkg::stage_t            stage
);
  import pfrsc_pkg::*;

  logic              valid_r;
  logic              valid_nxt;
  logic [1:0]        req_r;
  logic [BYTE_W-1:0] byte_r;
  logic              take;

  // the register frees up in the same cycle the core consumes it
  assign in_ready = !valid_r || advance;
  assign take     = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      req_r  <= req_type;
      byte_r <= rx_byte;
    end
  end

  assign stage = '{valid: valid_r, req_type: req_r, rx_byte: byte_r};
endmodule

[rtl/core/pfrsc_core.sv]
// transfer state and per-beat packet/checksum logic
// depends on pfrsc_pkg
module pfrsc_core #(
  parameter int PACKET_BYTES = 1000
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pfrsc_pkg::stage_t           stage,
  input  logic                        advance,
  input  logic [pfrsc_pkg::LEN_W-1:0] file_length,
  output pfrsc_pkg::result_t          result
);
  import pfrsc_pkg::*;

  localparam int PKT_CNT_W = $clog2(PACKET_BYTES + 1);
  // position also counts the four checksum bytes
  localparam int POS_W = (PKT_CNT_W < 2) ? 2 : PKT_CNT_W;
  localparam logic [LEN_W-1:0] PKT_LEN = LEN_W'(PACKET_BYTES);

  phase_t           phase_r, phase_nxt;
  logic [LEN_W-1:0] rem_r, rem_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [SUM_W-1:0] run_sum_r, run_sum_nxt;
  logic [SUM_W-1:0] sent_sum_r, sent_sum_nxt;

  logic [POS_W-1:0] plen;
  logic [POS_W-1:0] pos_inc;
  logic [LEN_W-1:0] rem_after;
  logic [SUM_W-1:0] sent_full;

  assign plen      = (rem_r > PKT_LEN) ? POS_W'(PACKET_BYTES) : rem_r[POS_W-1:0];
  assign pos_inc   = pos_r + 1'b1;
  assign rem_after = rem_r - {{(LEN_W-POS_W){1'b0}}, plen};
  assign sent_full = sent_sum_r
                   | ({{(SUM_W-BYTE_W){1'b0}}, stage.rx_byte} << {pos_r[1:0], 3'b000});

  always_comb begin
    phase_nxt    = phase_r;
    rem_nxt      = rem_r;
    pos_nxt      = pos_r;
    run_sum_nxt  = run_sum_r;
    sent_sum_nxt = sent_sum_r;
    result       = '0;

    case (stage.req_type)
      REQ_START: begin
        pos_nxt      = '0;
        run_sum_nxt  = '0;
        sent_sum_nxt = '0;
        rem_nxt      = file_length;
        if (file_length == '0) begin
          phase_nxt            = PH_IDLE;
          result.valid         = 1'b1;
          result.result_kind   = KIND_ACCEPT;
          result.transfer_done = 1'b1;
        end else begin
          phase_nxt = PH_DATA;
        end
      end
      REQ_TIMEOUT: begin
        if (phase_r != PH_IDLE) begin
          phase_nxt          = PH_IDLE;
          rem_nxt            = '0;
          pos_nxt            = '0;
          run_sum_nxt        = '0;
          sent_sum_nxt       = '0;
          result.valid       = 1'b1;
          result.result_kind = KIND_ABORT;
        end
      end
      REQ_BYTE: begin
        case (phase_r)
          PH_DATA: begin
            run_sum_nxt = run_sum_r + {{(SUM_W-BYTE_W){1'b0}}, stage.rx_byte};
            if (pos_inc >= plen) begin
              phase_nxt = PH_CHECK;
              pos_nxt   = '0;
            end else begin
              pos_nxt = pos_inc;
            end
            result.valid       = 1'b1;
            result.result_kind = KIND_DATA;
            result.data_out    = stage.rx_byte;
          end
          PH_CHECK: begin
            if (pos_r[1:0] != 2'd3) begin
              sent_sum_nxt = sent_full;
              pos_nxt      = pos_inc;
            end else begin
              pos_nxt      = '0;
              run_sum_nxt  = '0;
              sent_sum_nxt = '0;
              result.valid = 1'b1;
              if (sent_full != run_sum_r) begin
                // same packet comes again
                phase_nxt          = PH_DATA;
                result.result_kind = KIND_REJECT;
              end else begin
                rem_nxt            = rem_after;
                result.result_kind = KIND_ACCEPT;
                if (rem_after == '0) begin
                  phase_nxt            = PH_IDLE;
                  result.transfer_done = 1'b1;
                end else begin
                  phase_nxt = PH_DATA;
                end
              end
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase

    if (!(stage.valid && advance)) begin
      result.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      rem_r      <= '0;
      pos_r      <= '0;
      run_sum_r  <= '0;
      sent_sum_r <= '0;
    end else if (stage.valid && advance) begin
      phase_r    <= phase_nxt;
      rem_r      <= rem_nxt;
      pos_r      <= pos_nxt;
      run_sum_r  <= run_sum_nxt;
      sent_sum_r <= sent_sum_nxt;
    end
  end
endmodule

[rtl/core/pfrsc_out_stage.sv]
// result register toward the output channel
// depends on pfrsc_pkg
module pfrsc_out_stage (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pfrsc_pkg::result_t           result,
  output logic                         advance,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   result_kind,
  output logic [pfrsc_pkg::BYTE_W-1:0] data_out,
  output logic                         transfer_done
);
  import pfrsc_pkg::*;

  logic              valid_r;
  logic              valid_nxt;
  logic [1:0]        kind_r;
  logic [BYTE_W-1:0] data_r;
  logic              done_r;

  // free when empty or the held beat leaves this cycle
  assign advance = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (advance) begin
      valid_nxt = result.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result.valid) begin
      kind_r <= result.result_kind;
      data_r <= result.data_out;
      done_r <= result.transfer_done;
    end
  end

  assign out_valid     = valid_r;
  assign result_kind   = kind_r;
  assign data_out      = data_r;
  assign transfer_done = done_r;
endmodule

[rtl/core/pfrsc_checker.sv]
// port-level checks for the packet file receiver, bound to the top level
// depends on pfrsc_pkg and packet_file_receiver_sum_check_macros.svh
`include "packet_file_receiver_sum_check_macros.svh"

module pfrsc_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [1:0]                   result_kind,
  input logic [pfrsc_pkg::BYTE_W-1:0] data_out,
  input logic                         transfer_done
);
  import pfrsc_pkg::*;

  // a result beat waiting on the sink stays offered
  `PFRSC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result beat dropped")

  // an open output path never backs up the input
  `PFRSC_ASSERT_NOW(a_no_false_stall, out_ready, in_ready, "input stalled with sink ready")

  // only data beats carry a byte
  `PFRSC_ASSERT_NOW(a_data_zero, out_valid && (result_kind != KIND_DATA), data_out == '0, "byte on verdict beat")

  // completion only rides on an accept
  `PFRSC_ASSERT_NOW(a_done_accept, out_valid && transfer_done, result_kind == KIND_ACCEPT, "done without accept")
endmodule

bind packet_file_receiver_sum_check pfrsc_checker u_pfrsc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .result_kind   (out_ch.result_kind),
  .data_out      (out_ch.data_out),
  .transfer_done (out_ch.transfer_done)
);
